// File: rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the order record table engine.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition checked on every clock, disabled in reset.
`define ASSERT_IMPL(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Plain invariant checked on every clock.
`define ASSERT_ALWAYS(label, clk, cond, msg) \
   label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// File: rtl/core/ortbl_pkg.sv
// Types and constants of the order record table engine.
// No dependencies.
package ortbl_pkg;

   localparam int unsigned IdW   = 16;
   localparam int unsigned CustW = 27;
   localparam int unsigned KindW = 3;
   localparam int unsigned AreaW = 16;
   localparam int unsigned DateW = 23;
   localparam int unsigned CntW  = 6;
   localparam int unsigned MaxResults = 32;

   localparam logic [2:0] ModeAppend = 3'd0;
   localparam logic [2:0] ModeSort   = 3'd1;
   localparam logic [2:0] ModeQuery  = 3'd2;
   localparam logic [2:0] ModeUpdate = 3'd3;
   localparam logic [2:0] ModePurge  = 3'd4;

   localparam logic [1:0] StDone     = 2'd0;
   localparam logic [1:0] StFull     = 2'd1;
   localparam logic [1:0] StNotFound = 2'd2;
   localparam logic [1:0] StRecord   = 2'd3;

   typedef struct packed {
      logic [IdW-1:0]   order_id;
      logic [CustW-1:0] customer;
      logic [KindW-1:0] kind;
      logic [AreaW-1:0] area;
      logic             delivered;
      logic [DateW-1:0] request_date;
      logic [DateW-1:0] delivery_date;
   } record_type;

   typedef struct packed {
      logic [2:0]       mode;
      logic [IdW-1:0]   order_id;
      logic [CustW-1:0] customer_number;
      logic [KindW-1:0] material_kind;
      logic [AreaW-1:0] area_amount;
      logic             delivered_flag;
      logic [DateW-1:0] request_date;
      logic [DateW-1:0] delivery_date;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IdW-1:0]   out_order_id;
      logic [CustW-1:0] out_customer;
      logic [KindW-1:0] out_kind;
      logic [AreaW-1:0] out_area;
      logic             out_delivered;
      logic [DateW-1:0] out_request_date;
      logic [DateW-1:0] out_delivery_date;
      logic [CntW-1:0]  entry_count;
      logic             last;
   } rsp_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic       shift;    // rotate the chain by one place
      logic       sort;     // compare-exchange pass on the odd/even pairs
      logic       sort_odd; // pairs start at odd index
      logic       purge;    // order pairs by kept-before-dropped instead of id
      logic       write_tail; // load the appended record into the tail cell
      logic       set_area;   // overwrite area of the record rotating into the tail
   } cell_ctl_type;

endpackage

// File: rtl/core/ortbl_if.sv
// Valid/ready channel interface for the order record table engine.
// No dependencies.
interface ortbl_if #(parameter type PayloadType = logic) ();
   logic       valid;
   logic       ready;
   PayloadType payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/ortbl_cell.sv
// One table cell: holds a record and trades it with its neighbors.
// Depends on ortbl_pkg.
module ortbl_cell (
   input  logic                   clock,
   input  ortbl_pkg::cell_ctl_type ctl,
   input  logic                   is_odd,     // this cell sits at an odd index
   input  logic                   up_live,    // cell above exists and both hold records
   input  logic                   dn_live,    // cell below exists and both hold records
   input  ortbl_pkg::record_type  from_up,    // record of next-higher cell
   input  ortbl_pkg::record_type  from_down,  // record of next-lower cell
   input  ortbl_pkg::record_type  load_rec,
   input  logic                   load_sel,
   input  logic                   area_sel,
   input  logic [ortbl_pkg::AreaW-1:0] area_val,
   input  logic [ortbl_pkg::DateW-1:0] threshold,
   output ortbl_pkg::record_type  rec
);
   import ortbl_pkg::*;
   record_type rec_ff, rec_in;
   logic lower_of_pair;
   logic up_first, self_first;

   assign rec = rec_ff;

   // In a sort step, this cell is the lower of a pair if its parity matches.
   assign lower_of_pair = (is_odd == ctl.sort_odd);

   // Strict ordering keeps equal keys in place (stable).
   assign up_first = ctl.purge ?
      (from_up.request_date >= threshold && rec_ff.request_date < threshold) :
      (from_up.order_id < rec_ff.order_id);
   assign self_first = ctl.purge ?
      (rec_ff.request_date >= threshold && from_down.request_date < threshold) :
      (rec_ff.order_id < from_down.order_id);

   always_comb begin
      rec_in = rec_ff;
      if (ctl.shift) begin
         rec_in = from_up;
         if (ctl.set_area && area_sel) rec_in.area = area_val;
      end else if (ctl.sort) begin
         if (lower_of_pair) begin
            if (up_live && up_first) rec_in = from_up;
         end else begin
            if (dn_live && self_first) rec_in = from_down;
         end
      end else if (ctl.write_tail && load_sel) begin
         rec_in = load_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end
endmodule

// File: rtl/core/order_record_table_engine.sv
// Top level of the order record table engine: control sequencer and cell chain.
// Depends on ortbl_pkg, ortbl_if, ortbl_cell and assert_macros.svh.
//
//  channel | role   | payload
//  req     | sink   | mode, key and record fields
//  rsp     | source | status, record fields, entry_count, last
//
// Append and unused modes: a load step and a close step. Query and update:
// DEPTH rotation steps, then a close step. Sort and purge: DEPTH odd/even
// compare-exchange steps, then DEPTH rotation steps, then a close step. An
// unclaimed rsp holds the rotation steps and the close in place. Reset empties
// the table.
module order_record_table_engine #(
   parameter int unsigned DEPTH = 32
) (
   input logic clock,
   input logic reset,
   ortbl_if.sink   req,
   ortbl_if.source rsp
);
   import ortbl_pkg::*;
   localparam int unsigned IdxW = $clog2(DEPTH);
   localparam int unsigned StepW = $clog2(DEPTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SORT = 3'd1;
   localparam logic [2:0] S_WALK = 3'd2;
   localparam logic [2:0] S_ONE  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]       state_ff, state_in;
   req_type          cmd_ff, cmd_in;
   logic [StepW-1:0] step_ff, step_in;  // rotations/sort steps done
   logic [StepW-1:0] count_ff, count_in; // records held
   logic [StepW-1:0] kept_ff, kept_in;  // purge survivors
   logic [StepW-1:0] emitted_ff, emitted_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   rsp_type          hold_ff, hold_in; // newest record result, not yet sent
   logic             pend_ff, pend_in; // hold_ff holds a record result

   cell_ctl_type ctl;
   record_type   recs [DEPTH];
   record_type   new_rec;
   logic [DEPTH-1:0] load_sel;
   logic [DEPTH-1:0] up_live;
   logic [DEPTH-1:0] dn_live;
   logic         tail_valid;
   record_type   head;
   logic         walk_step, head_live, head_hit, last_step;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
   assign head = recs[0];

   assign new_rec = '{order_id: cmd_ff.order_id, customer: cmd_ff.customer_number,
                      kind: cmd_ff.material_kind, area: cmd_ff.area_amount,
                      delivered: cmd_ff.delivered_flag,
                      request_date: cmd_ff.request_date,
                      delivery_date: cmd_ff.delivery_date};

   // Cell chain. Rotation moves cell 0 to cell DEPTH-1, so a full turn puts
   // every record back in place. Purge first moves survivors to the front.
   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         localparam int unsigned Up = (g + 1) % DEPTH;
         localparam int unsigned Dn = (g + DEPTH - 1) % DEPTH;
         assign load_sel[g] = (count_ff[IdxW-1:0] == IdxW'(g));
         assign up_live[g] = 1'(g + 1 < DEPTH) && (StepW'(g + 1) < count_ff);
         assign dn_live[g] = 1'(g >= 1) && (StepW'(g) < count_ff);
         ortbl_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .is_odd    (1'((g % 2) == 1)),
            .up_live   (up_live[g]),
            .dn_live   (dn_live[g]),
            .from_up   (recs[Up]),
            .from_down (recs[Dn]),
            .load_rec  (new_rec),
            .load_sel  (load_sel[g]),
            .area_sel  (1'(g == DEPTH - 1)),
            .area_val  (cmd_ff.area_amount),
            .threshold (cmd_ff.request_date),
            .rec       (recs[g])
         );
      end
   endgenerate

   // Head record is live when its original index is below the record count.
   assign head_live = (step_ff < count_ff);
   assign last_step = (step_ff == StepW'(DEPTH - 1));
   assign tail_valid = (count_ff < StepW'(DEPTH));

   always_comb begin
      unique case (cmd_ff.mode)
         ModeSort:   head_hit = head_live;
         ModeQuery:  head_hit = head_live && (head.customer == cmd_ff.customer_number);
         ModeUpdate: head_hit = head_live && !found_ff && (head.order_id == cmd_ff.order_id);
         ModePurge:  head_hit = head_live && (head.request_date >= cmd_ff.request_date);
         default:    head_hit = 1'b0;
      endcase
   end

   // A walk step may not proceed while the output register is unclaimed.
   assign walk_step = (state_ff == S_WALK) && !(rsp_valid_ff && !rsp.ready);

   always_comb begin
      state_in = state_ff;  cmd_in = cmd_ff;  step_in = step_ff;
      count_in = count_ff;  kept_in = kept_ff; emitted_in = emitted_ff;
      found_in = found_ff;  rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      hold_in = hold_ff;    pend_in = pend_ff;
      ctl = '0;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in = req.payload;
               step_in = '0; kept_in = '0; emitted_in = '0; found_in = 1'b0;
               pend_in = 1'b0;
               if (req.payload.mode == ModeSort || req.payload.mode == ModePurge)
                  state_in = S_SORT;
               else if (req.payload.mode == ModeQuery || req.payload.mode == ModeUpdate)
                  state_in = S_WALK;
               else state_in = S_ONE;
            end
         end
         S_SORT: begin
            // Odd/even transposition over the live cells only.
            ctl.sort = 1'b1;
            ctl.sort_odd = step_ff[0];
            ctl.purge = (cmd_ff.mode == ModePurge);
            step_in = step_ff + 1'b1;
            if (last_step) begin
               step_in = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (walk_step) begin
               ctl.shift = 1'b1;
               step_in = step_ff + 1'b1;
               if (cmd_ff.mode == ModeUpdate && head_hit) begin
                  ctl.set_area = 1'b1;
                  found_in = 1'b1;
               end
               if (cmd_ff.mode == ModePurge && head_hit) kept_in = kept_ff + 1'b1;
               if ((cmd_ff.mode == ModeSort || cmd_ff.mode == ModeQuery) && head_hit
                   && 32'(emitted_ff) < MaxResults) begin
                  // Send the held record, keep the new one until the next hit or the close.
                  if (pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = hold_ff;
                  end
                  pend_in = 1'b1;
                  emitted_in = emitted_ff + 1'b1;
                  hold_in = '{status: StRecord, out_order_id: head.order_id,
                              out_customer: head.customer, out_kind: head.kind,
                              out_area: head.area, out_delivered: head.delivered,
                              out_request_date: head.request_date,
                              out_delivery_date: head.delivery_date,
                              entry_count: CntW'(count_ff), last: 1'b0};
               end
               if (last_step) state_in = S_OUT;
            end
         end
         S_ONE: begin
            if (cmd_ff.mode == ModeAppend && tail_valid) begin
               ctl.write_tail = 1'b1;
               count_in = count_ff + 1'b1;
               found_in = 1'b1;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // Close the request: the held record goes out as last, or a status.
            if (!(rsp_valid_ff && !rsp.ready)) begin
               rsp_valid_in = 1'b1;
               pend_in = 1'b0;
               state_in = S_IDLE;
               if (pend_ff) begin
                  rsp_in = hold_ff;
                  rsp_in.last = 1'b1;
               end else begin
                  rsp_in = '0;
                  rsp_in.last = 1'b1;
                  unique case (cmd_ff.mode)
                     ModeAppend: begin
                        rsp_in.status = found_ff ? StDone : StFull;
                        rsp_in.entry_count = CntW'(count_ff);
                     end
                     ModeSort, ModeQuery: begin
                        rsp_in.status = (cmd_ff.mode == ModeSort) ? StDone : StNotFound;
                        rsp_in.entry_count = CntW'(count_ff);
                     end
                     ModeUpdate: begin
                        rsp_in.status = found_ff ? StDone : StNotFound;
                        rsp_in.entry_count = CntW'(count_ff);
                     end
                     ModePurge: begin
                        rsp_in.status = StDone;
                        rsp_in.entry_count = CntW'(kept_ff);
                        count_in = kept_ff;
                     end
                     default: rsp_in.entry_count = CntW'(count_ff);
                  endcase
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff <= pend_in;
      end
      cmd_ff <= cmd_in; step_ff <= step_in; kept_ff <= kept_in;
      emitted_ff <= emitted_in; found_ff <= found_in; rsp_ff <= rsp_in;
      hold_ff <= hold_in;
   end

   `include "assert_macros.svh"
   `ASSERT_IMPL(a_count_range, clock, reset, count_ff <= StepW'(DEPTH), "count over depth")
   `ASSERT_IMPL(a_ready_idle, clock, reset, !(req.ready && state_ff != S_IDLE), "ready")
   `ASSERT_IMPL(a_rsp_hold, clock, reset,
      !($past(rsp_valid_ff && !rsp.ready) && !$past(reset)) || rsp_valid_ff, "rsp dropped")
endmodule
